@@ rtl/wkc_pkg.sv @@
// Shared constants and types of the weighted k-mer consensus block.
`default_nettype none

package wkc_pkg;

  // Default number of bases in one k-mer.
  localparam int unsigned KmerLenDef = 21;

  // Widths fixed by the interface.
  localparam int unsigned CountW = 32;
  localparam int unsigned LabelW = 10;
  localparam int unsigned ScoreW = 48;
  localparam int unsigned CfgW   = 10;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_USE_MASK   = 1'b0,
    REG_MASK_VALUE = 1'b1
  } wkc_reg_e;

  // Finish control handed from the top level to the merge stage.
  typedef struct packed {
    logic load;
    logic single;
  } wkc_fin_t;

endpackage

`default_nettype wire

@@ rtl/wkc_lane.sv @@
// One position lane: four saturating base scores and their winner.
`default_nettype none

module wkc_lane (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 upd_i,
  input  logic                                 clr_i,
  input  logic [1:0]                           base_i,
  input  logic [wkc_pkg::CountW-1:0]           count_i,
  output logic [1:0]                           best_o
);

  logic [wkc_pkg::ScoreW-1:0] score_q [4];
  logic [wkc_pkg::ScoreW-1:0] score_d [4];
  logic [wkc_pkg::ScoreW:0]   sum;
  logic [1:0]                 best01;
  logic [1:0]                 best23;

  always_comb begin
    sum = {1'b0, score_q[base_i]} + {{(wkc_pkg::ScoreW + 1 - wkc_pkg::CountW){1'b0}}, count_i};
    for (int b = 0; b < 4; b++) begin
      score_d[b] = score_q[b];
    end
    if (clr_i) begin
      for (int b = 0; b < 4; b++) begin
        score_d[b] = '0;
      end
    end else if (upd_i) begin
      score_d[base_i] = sum[wkc_pkg::ScoreW] ? {wkc_pkg::ScoreW{1'b1}}
                                             : sum[wkc_pkg::ScoreW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < 4; b++) begin
        score_q[b] <= '0;
      end
    end else begin
      for (int b = 0; b < 4; b++) begin
        score_q[b] <= score_d[b];
      end
    end
  end

  // Ties go to the lower code: a higher code wins only on a strict greater.
  always_comb begin
    best01 = (score_q[1] > score_q[0]) ? 2'd1 : 2'd0;
    best23 = (score_q[3] > score_q[2]) ? 2'd3 : 2'd2;
    best_o = (score_q[best23] > score_q[best01]) ? best23 : best01;
  end

endmodule

`default_nettype wire

@@ rtl/wkc_merge.sv @@
// Merge: result register for lane winners or a lone request's bases.
`default_nettype none

module wkc_merge #(
  parameter int unsigned KMER_LEN = wkc_pkg::KmerLenDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  wkc_pkg::wkc_fin_t       fin_i,
  input  logic [2*KMER_LEN-1:0]   lane_best_i,
  input  logic [2*KMER_LEN-1:0]   first_bases_i,
  output logic                    free_o,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2*KMER_LEN-1:0]   consensus_bases_o
);

  logic                  valid_q, valid_d;
  logic [2*KMER_LEN-1:0] data_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (fin_i.load) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_i.load) begin
      data_q <= fin_i.single ? first_bases_i : lane_best_i;
    end
  end

  assign out_valid_o       = valid_q;
  assign consensus_bases_o = data_q;

endmodule

`default_nettype wire

@@ rtl/weighted_kmer_consensus.sv @@
// Top level of the weighted k-mer consensus block.
//
//  Channel  Direction  Handshake               Payload
//  in       input      in_valid_i/in_stall_o   kmer_bases_i, kmer_count_i,
//                                              cluster_label_i, last_in_block_i
//  out      output     out_valid_o/out_stall_i consensus_bases_o
//  cfg      input      cfg_we_i                cfg_idx_i, cfg_wdata_i
//
// A request is taken every cycle but while a block finishes; one lane per base
// position adds the count to its score for that base in the cycle the request
// is accepted and its label passes the mask (when enabled). A last-of-block
// request starts a finish state that loads the lanes' winners (for a block of
// one, its request's bases) into the output register and clears the scores;
// it waits while a previous result is still held by a stalled output.
// Reset clears all scores and control state at once; there is no clearing pass.
`default_nettype none

module weighted_kmer_consensus #(
  parameter int unsigned KMER_LEN = wkc_pkg::KmerLenDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [0:0]                   cfg_idx_i,
  input  logic [wkc_pkg::CfgW-1:0]     cfg_wdata_i,
  // Input channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2*KMER_LEN-1:0]        kmer_bases_i,
  input  logic [wkc_pkg::CountW-1:0]   kmer_count_i,
  input  logic [wkc_pkg::LabelW-1:0]   cluster_label_i,
  input  logic                         last_in_block_i,
  // Output channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [2*KMER_LEN-1:0]        consensus_bases_o
);

  logic                       use_mask_q;
  logic [wkc_pkg::LabelW-1:0] mask_value_q;

  logic                  in_acc;
  logic                  votes;
  logic                  seen_q, seen_d;
  logic                  fin_q, fin_d;
  logic                  single_q, single_d;
  logic [2*KMER_LEN-1:0] first_q;
  logic [2*KMER_LEN-1:0] lane_best;
  logic                  merge_free;
  wkc_pkg::wkc_fin_t     fin;

  // Configuration registers; the user writes them only when idle: not enforced.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_mask_q   <= 1'b0;
      mask_value_q <= '0;
    end else if (cfg_we_i) begin
      unique case (wkc_pkg::wkc_reg_e'(cfg_idx_i))
        wkc_pkg::REG_USE_MASK:   use_mask_q   <= cfg_wdata_i[0];
        wkc_pkg::REG_MASK_VALUE: mask_value_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The input side only holds off while a block is finishing.
  assign in_stall_o = fin_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign votes      = !use_mask_q || (cluster_label_i == mask_value_q);

  assign fin.load   = fin_q && merge_free;
  assign fin.single = single_q;

  // Block tracking: whether any request of the current block was taken, and
  // whether the finishing block held a single request.
  always_comb begin
    seen_d   = seen_q;
    fin_d    = fin_q;
    single_d = single_q;
    if (in_acc) begin
      seen_d = !last_in_block_i;
      if (last_in_block_i) begin
        fin_d    = 1'b1;
        single_d = !seen_q;
      end
    end else if (fin.load) begin
      fin_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 1'b0;
      fin_q    <= 1'b0;
      single_q <= 1'b0;
    end else begin
      seen_q   <= seen_d;
      fin_q    <= fin_d;
      single_q <= single_d;
    end
  end

  // The first request's bases are the answer for a block of one.
  always_ff @(posedge clk_i) begin
    if (in_acc && !seen_q) begin
      first_q <= kmer_bases_i;
    end
  end

  // One lane per base position.
  for (genvar g = 0; g < KMER_LEN; g++) begin : g_lane
    wkc_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .upd_i   (in_acc && votes),
      .clr_i   (fin.load),
      .base_i  (kmer_bases_i[2*g +: 2]),
      .count_i (kmer_count_i),
      .best_o  (lane_best[2*g +: 2])
    );
  end

  wkc_merge #(
    .KMER_LEN (KMER_LEN)
  ) u_merge (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fin_i             (fin),
    .lane_best_i       (lane_best),
    .first_bases_i     (first_q),
    .free_o            (merge_free),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .consensus_bases_o (consensus_bases_o)
  );

  // A last request always leads into the finish cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_in_block_i) |=> fin_q)
    else $error("last request did not start the finish cycle");

  // A new result only appears right after a finish cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(fin_q))
    else $error("result appeared without a finished block");

  // A block of one returns the bases of its only request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin.load && single_q) |=> (consensus_bases_o == $past(first_q)))
    else $error("single-request block did not return its bases");

  // The finish cycle ends once the result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin.load |=> !fin_q)
    else $error("finish cycle did not end after loading the result");

endmodule

`default_nettype wire
